// ===== rtl/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared constants, codes, types and helpers of the grid path cursor.
// ----------------------------------------------------------------------------
package gpc_pkg;

    localparam int COLS     = 4;
    localparam int ROWS     = 4;
    localparam int CELLS    = ROWS * COLS;
    localparam int IDX_W    = $clog2(CELLS);
    localparam int POS_W    = 3;
    localparam int LETTER_W = 8;
    localparam int FUNC_W   = 3;
    localparam int DIR_W    = 3;
    localparam int PATH_W   = 7;
    localparam int ENTRY_W  = 2 * POS_W + LETTER_W;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 3'd0,
        FUNC_START = 3'd1,
        FUNC_MOVE  = 3'd2,
        FUNC_POP   = 3'd3,
        FUNC_READ  = 3'd4
    } func_t;

    localparam logic [DIR_W-1:0] DIR_UP        = 3'd0;
    localparam logic [DIR_W-1:0] DIR_UPLEFT    = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UPRIGHT   = 3'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN      = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWNLEFT  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_DOWNRIGHT = 3'd5;
    localparam logic [DIR_W-1:0] DIR_LEFT      = 3'd6;
    localparam logic [DIR_W-1:0] DIR_RIGHT     = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0]    col;
        logic [POS_W-1:0]    row;
        logic [LETTER_W-1:0] letter;
    } entry_t;

    function automatic logic signed [1:0] step_x(input logic [DIR_W-1:0] dir);
        logic signed [1:0] d;
        case (dir) inside
            DIR_UPLEFT, DIR_DOWNLEFT, DIR_LEFT:    d = -2'sd1;
            DIR_UPRIGHT, DIR_DOWNRIGHT, DIR_RIGHT: d = 2'sd1;
            default:                               d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] step_y(input logic [DIR_W-1:0] dir);
        logic signed [1:0] d;
        case (dir) inside
            DIR_UP, DIR_UPLEFT, DIR_UPRIGHT:       d = -2'sd1;
            DIR_DOWN, DIR_DOWNLEFT, DIR_DOWNRIGHT: d = 2'sd1;
            default:                               d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic [IDX_W-1:0] cell_index(input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col);
        return IDX_W'(int'(row) * COLS + int'(col));
    endfunction

    function automatic logic col_in_range(input logic signed [POS_W+1:0] c);
        return (int'(c) >= 0) && (int'(c) < COLS);
    endfunction

    function automatic logic row_in_range(input logic signed [POS_W+1:0] r);
        return (int'(r) >= 0) && (int'(r) < ROWS);
    endfunction

endpackage

// ===== rtl/gpc_req_if.sv =====
// ----------------------------------------------------------------------------
// gpc_req_if
// Request channel of the grid path cursor: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface gpc_req_if;
    logic                          valid;
    logic                          ready;
    logic [gpc_pkg::FUNC_W-1:0]    func;
    logic [gpc_pkg::POS_W-1:0]     col;
    logic [gpc_pkg::POS_W-1:0]     row;
    logic [gpc_pkg::DIR_W-1:0]     direction;
    logic [gpc_pkg::LETTER_W-1:0]  cell_letter;

    modport source (output valid, func, col, row, direction, cell_letter, input ready);
    modport sink   (input valid, func, col, row, direction, cell_letter, output ready);
endinterface

// ===== rtl/gpc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gpc_rsp_if
// Response channel of the grid path cursor: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface gpc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          ok;
    logic [gpc_pkg::LETTER_W-1:0]  letter;
    logic [gpc_pkg::POS_W-1:0]     cur_col;
    logic [gpc_pkg::POS_W-1:0]     cur_row;
    logic [gpc_pkg::PATH_W-1:0]    path_len;
    logic                          last;

    modport source (output valid, ok, letter, cur_col, cur_row, path_len, last, input ready);
    modport sink   (input valid, ok, letter, cur_col, cur_row, path_len, last, output ready);
endinterface

// ===== rtl/gpc_ram.sv =====
// ----------------------------------------------------------------------------
// gpc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/grid_path_cursor.sv =====
// ----------------------------------------------------------------------------
// grid_path_cursor
// Cursor over a letter grid with a path stack, one command at a time.
// ----------------------------------------------------------------------------
// Commands arrive on req (valid/ready); each is taken only while the block is
// idle, and ready stays low until every result of that command is taken on rsp.
// Every command returns one transaction with last set, except read word with a
// cursor placed, which returns one transaction per path position, oldest first,
// with last on the final one.
// A move first runs a visited-position check, which walks the stack RAM
// through its single read port, one entry per cycle.
// Grid and stack live in two small RAMs with no reset; reset only clears the
// sequencer, the path depth, the cursor flag and the result and compare
// valid flags, so the block is ready as soon as reset is released. A stalled
// rsp holds the result register and the sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module grid_path_cursor (
    input  logic      clk,
    input  logic      rst_n,
    gpc_req_if.sink   req,
    gpc_rsp_if.source rsp
);

    import gpc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_GRID_WAIT = 11'b000_0000_0010,
        S_START     = 11'b000_0000_0100,
        S_SCAN      = 11'b000_0000_1000,
        S_MOVE      = 11'b000_0001_0000,
        S_POP_RD    = 11'b000_0010_0000,
        S_POP       = 11'b000_0100_0000,
        S_RW_RD     = 11'b000_1000_0000,
        S_RW_OUT    = 11'b001_0000_0000,
        S_RESP      = 11'b010_0000_0000,
        S_EMIT      = 11'b100_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [PATH_W-1:0]   depth_reg, depth_next;
    logic                active_reg, active_next;
    entry_t              top_reg, top_next;
    logic [POS_W-1:0]    tgt_col_reg, tgt_col_next;
    logic [POS_W-1:0]    tgt_row_reg, tgt_row_next;
    logic [PATH_W-1:0]   scan_reg, scan_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                seen_reg, seen_next;
    logic [PATH_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                ok_reg, ok_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;
    logic [LETTER_W-1:0] out_letter_reg, out_letter_next;
    logic [POS_W-1:0]    out_col_reg, out_col_next;
    logic [POS_W-1:0]    out_row_reg, out_row_next;
    logic [PATH_W-1:0]   out_len_reg, out_len_next;
    logic                out_last_reg, out_last_next;

    logic                    grid_we;
    logic [IDX_W-1:0]        grid_rd_addr;
    logic [LETTER_W-1:0]     grid_rd_data;
    logic                    stack_we;
    logic [IDX_W-1:0]        stack_wr_addr;
    entry_t                  stack_wr_data;
    logic [IDX_W-1:0]        stack_rd_addr;
    logic [ENTRY_W-1:0]      stack_rd_raw;
    entry_t                  stack_rd_data;

    logic                    accept;
    logic signed [POS_W+1:0] next_col;
    logic signed [POS_W+1:0] next_row;
    logic                    scan_issue;
    entry_t                  cur;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign stack_rd_data = entry_t'(stack_rd_raw);
    assign grid_rd_addr  = cell_index(tgt_row_reg, tgt_col_reg);

    // cursor as seen on the result fields: all zero until a start succeeds
    assign cur = active_reg ? top_reg : '0;

    assign next_col   = $signed({2'b00, top_reg.col}) + step_x(req.direction);
    assign next_row   = $signed({2'b00, top_reg.row}) + step_y(req.direction);
    assign scan_issue = (scan_reg < depth_reg);

    gpc_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (CELLS)
    ) u_grid_ram (
        .clk     (clk),
        .we      (grid_we),
        .wr_addr (cell_index(req.row, req.col)),
        .wr_data (req.cell_letter),
        .rd_addr (grid_rd_addr),
        .rd_data (grid_rd_data)
    );

    gpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .clk     (clk),
        .we      (stack_we),
        .wr_addr (stack_wr_addr),
        .wr_data (stack_wr_data),
        .rd_addr (stack_rd_addr),
        .rd_data (stack_rd_raw)
    );

    always_comb
    begin
        unique case (state_reg)
            S_POP_RD: stack_rd_addr = IDX_W'(depth_reg - PATH_W'(2));
            S_RW_RD:  stack_rd_addr = rd_idx_reg[IDX_W-1:0];
            default:  stack_rd_addr = scan_reg[IDX_W-1:0];
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        active_next     = active_reg;
        top_next        = top_reg;
        tgt_col_next    = tgt_col_reg;
        tgt_row_next    = tgt_row_reg;
        scan_next       = scan_reg;
        cmp_valid_next  = cmp_valid_reg;
        seen_next       = seen_reg;
        rd_idx_next     = rd_idx_reg;
        ok_next         = ok_reg;
        out_valid_next  = out_valid_reg;
        out_ok_next     = out_ok_reg;
        out_letter_next = out_letter_reg;
        out_col_next    = out_col_reg;
        out_row_next    = out_row_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        grid_we         = 1'b0;
        stack_we        = 1'b0;
        stack_wr_addr   = depth_reg[IDX_W-1:0];
        stack_wr_data   = '{col: tgt_col_reg, row: tgt_row_reg, letter: grid_rd_data};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ok_next    = 1'b0;
                    state_next = S_RESP;
                    unique case (req.func)
                        FUNC_LOAD:
                        begin
                            if (col_in_range({2'b00, req.col}) && row_in_range({2'b00, req.row}))
                            begin
                                grid_we = 1'b1;
                                ok_next = 1'b1;
                            end
                        end
                        FUNC_START:
                        begin
                            if (col_in_range({2'b00, req.col}) && row_in_range({2'b00, req.row}))
                            begin
                                tgt_col_next = req.col;
                                tgt_row_next = req.row;
                                state_next   = S_GRID_WAIT;
                            end
                        end
                        FUNC_MOVE:
                        begin
                            if (active_reg && (int'(depth_reg) < CELLS)
                                && col_in_range(next_col) && row_in_range(next_row))
                            begin
                                tgt_col_next   = next_col[POS_W-1:0];
                                tgt_row_next   = next_row[POS_W-1:0];
                                scan_next      = '0;
                                cmp_valid_next = 1'b0;
                                seen_next      = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (active_reg && (depth_reg > PATH_W'(1)))
                            begin
                                state_next = S_POP_RD;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (active_reg)
                            begin
                                rd_idx_next = '0;
                                state_next  = S_RW_RD;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            S_GRID_WAIT:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                stack_we      = 1'b1;
                stack_wr_addr = '0;
                top_next      = stack_wr_data;
                depth_next    = PATH_W'(1);
                active_next   = 1'b1;
                ok_next       = 1'b1;
                state_next    = S_RESP;
            end
            S_SCAN:
            begin
                // reads are issued one entry per cycle, each compared in the cycle after its issue
                if (scan_issue)
                begin
                    scan_next = scan_reg + PATH_W'(1);
                end
                cmp_valid_next = scan_issue;
                if (cmp_valid_reg && (stack_rd_data.col == tgt_col_reg)
                    && (stack_rd_data.row == tgt_row_reg))
                begin
                    seen_next = 1'b1;
                end
                if (!scan_issue && !cmp_valid_reg)
                begin
                    state_next = seen_reg ? S_RESP : S_MOVE;
                end
            end
            S_MOVE:
            begin
                stack_we   = 1'b1;
                top_next   = stack_wr_data;
                depth_next = depth_reg + PATH_W'(1);
                ok_next    = 1'b1;
                state_next = S_RESP;
            end
            S_POP_RD:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                top_next   = stack_rd_data;
                depth_next = depth_reg - PATH_W'(1);
                ok_next    = 1'b1;
                state_next = S_RESP;
            end
            S_RW_RD:
            begin
                state_next = S_RW_OUT;
            end
            S_RW_OUT:
            begin
                out_valid_next  = 1'b1;
                out_ok_next     = 1'b1;
                out_letter_next = stack_rd_data.letter;
                out_col_next    = cur.col;
                out_row_next    = cur.row;
                out_len_next    = depth_reg;
                out_last_next   = (rd_idx_reg == depth_reg - PATH_W'(1));
                state_next      = S_EMIT;
            end
            S_RESP:
            begin
                out_valid_next  = 1'b1;
                out_ok_next     = ok_reg;
                out_letter_next = cur.letter;
                out_col_next    = cur.col;
                out_row_next    = cur.row;
                out_len_next    = depth_reg;
                out_last_next   = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (rsp.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg + PATH_W'(1);
                        state_next  = S_RW_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        tgt_col_reg    <= tgt_col_next;
        tgt_row_reg    <= tgt_row_next;
        scan_reg       <= scan_next;
        seen_reg       <= seen_next;
        rd_idx_reg     <= rd_idx_next;
        ok_reg         <= ok_next;
        out_ok_reg     <= out_ok_next;
        out_letter_reg <= out_letter_next;
        out_col_reg    <= out_col_next;
        out_row_reg    <= out_row_next;
        out_len_reg    <= out_len_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.ok       = out_ok_reg;
    assign rsp.letter   = out_letter_reg;
    assign rsp.cur_col  = out_col_reg;
    assign rsp.cur_row  = out_row_reg;
    assign rsp.path_len = out_len_reg;
    assign rsp.last     = out_last_reg;

    a_active_depth: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (depth_reg != '0) && (int'(depth_reg) <= CELLS))
        else $error("path depth out of range while cursor active");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !out_valid_reg)
        else $error("new command taken while a result is pending");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(depth_reg) |-> (depth_reg == PATH_W'(1))
            || (depth_reg == $past(depth_reg) + PATH_W'(1))
            || (depth_reg == $past(depth_reg) - PATH_W'(1)))
        else $error("path depth jumped by more than one");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_reg <= depth_reg))
        else $error("visited scan ran past the path depth");

endmodule

// ===== tb/tb_grid_path_cursor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_path_cursor
// Self-checking bench for the grid path cursor. A transaction-level copy of
// the cursor, grid and path stack predicts every response transaction;
// directed corner cases come first, then random walks, full snakes and noise,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_grid_path_cursor;
    import gpc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_PCT     = 16;
    localparam int RAND_ITEMS   = 375;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [POS_W-1:0]    col;
        logic [POS_W-1:0]    row;
        logic [DIR_W-1:0]    direction;
        logic [LETTER_W-1:0] cell_letter;
    } cmd_t;

    typedef struct packed {
        logic                ok;
        logic [LETTER_W-1:0] letter;
        logic [POS_W-1:0]    cur_col;
        logic [POS_W-1:0]    cur_row;
        logic [PATH_W-1:0]   path_len;
        logic                last;
    } res_t;

    logic clk;
    logic rst_n;

    gpc_req_if req_if ();
    gpc_rsp_if rsp_if ();

    grid_path_cursor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predicted cursor state
    logic [LETTER_W-1:0] grid_copy    [CELLS];
    logic                grid_written [CELLS];
    logic [POS_W-1:0]    path_col     [CELLS];
    logic [POS_W-1:0]    path_row     [CELLS];
    logic [LETTER_W-1:0] path_letter  [CELLS];
    int                  path_depth;
    logic                cursor_on;

    res_t results_due [$];
    int   errors;
    int   n_sent;
    int   idle_pct;
    int   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void dir_delta(input logic [DIR_W-1:0] d, output int dc, output int dr);
        dc = 0;
        dr = 0;
        case (d)
            DIR_UP:        dr = -1;
            DIR_UPLEFT:
            begin
                dc = -1;
                dr = -1;
            end
            DIR_UPRIGHT:
            begin
                dc = 1;
                dr = -1;
            end
            DIR_DOWN:      dr = 1;
            DIR_DOWNLEFT:
            begin
                dc = -1;
                dr = 1;
            end
            DIR_DOWNRIGHT:
            begin
                dc = 1;
                dr = 1;
            end
            DIR_LEFT:      dc = -1;
            default:       dc = 1;
        endcase
    endfunction

    function automatic logic [DIR_W-1:0] dir_toward(input int dc, input int dr);
        if (dr < 0)
            return (dc < 0) ? DIR_UPLEFT : (dc > 0) ? DIR_UPRIGHT : DIR_UP;
        else if (dr > 0)
            return (dc < 0) ? DIR_DOWNLEFT : (dc > 0) ? DIR_DOWNRIGHT : DIR_DOWN;
        else
            return (dc < 0) ? DIR_LEFT : DIR_RIGHT;
    endfunction

    // target of one step from the cursor; 1 if on the grid and not in the path
    function automatic logic free_step(input logic [DIR_W-1:0] d, output int nc, output int nr);
        int   dc;
        int   dr;
        logic clear;
        dir_delta(d, dc, dr);
        nc = int'(path_col[path_depth-1]) + dc;
        nr = int'(path_row[path_depth-1]) + dr;
        clear = (nc >= 0) && (nc < COLS) && (nr >= 0) && (nr < ROWS);
        for (int i = 0; i < path_depth; i++)
            if (int'(path_col[i]) == nc && int'(path_row[i]) == nr)
                clear = 1'b0;
        return clear;
    endfunction

    function automatic void due_result(input logic ok_bit, input logic [LETTER_W-1:0] ltr,
                                       input logic last_bit);
        res_t r;
        r.ok       = ok_bit;
        r.letter   = ltr;
        r.last     = last_bit;
        r.path_len = PATH_W'(path_depth);
        if (cursor_on && path_depth > 0)
        begin
            r.cur_col = path_col[path_depth-1];
            r.cur_row = path_row[path_depth-1];
        end
        else
        begin
            r.cur_col = '0;
            r.cur_row = '0;
        end
        results_due.insert(results_due.size(), r);
    endfunction

    function automatic void cursor_step(input cmd_t c);
        int   nc;
        int   nr;
        int   idx;
        logic done_ok;
        done_ok = 1'b0;
        idx = int'(c.row) * COLS + int'(c.col);
        case (c.func)
            FUNC_LOAD:
            begin
                if (c.col < COLS && c.row < ROWS)
                begin
                    grid_copy[idx]    = c.cell_letter;
                    grid_written[idx] = 1'b1;
                    done_ok = 1'b1;
                end
            end
            FUNC_START:
            begin
                if (c.col < COLS && c.row < ROWS)
                begin
                    path_col[0]    = c.col;
                    path_row[0]    = c.row;
                    path_letter[0] = grid_copy[idx];
                    path_depth     = 1;
                    cursor_on      = 1'b1;
                    done_ok = 1'b1;
                end
            end
            FUNC_MOVE:
            begin
                if (cursor_on && path_depth > 0 && path_depth < CELLS &&
                    free_step(c.direction, nc, nr))
                begin
                    path_col[path_depth]    = POS_W'(nc);
                    path_row[path_depth]    = POS_W'(nr);
                    path_letter[path_depth] = grid_copy[nr * COLS + nc];
                    path_depth++;
                    done_ok = 1'b1;
                end
            end
            FUNC_POP:
            begin
                if (cursor_on && path_depth > 1)
                begin
                    path_depth--;
                    done_ok = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (cursor_on && path_depth > 0)
                begin
                    for (int k = 0; k < path_depth; k++)
                        due_result(1'b1, path_letter[k], k == path_depth - 1);
                    return;
                end
            end
            default: ;
        endcase
        due_result(done_ok, (cursor_on && path_depth > 0) ? path_letter[path_depth-1] : '0,
                   1'b1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // one command transaction; a start or move that would read a never-loaded
    // cell turns into a load of that cell
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] col,
                            input logic [POS_W-1:0] row, input logic [DIR_W-1:0] dir,
                            input logic [LETTER_W-1:0] ltr);
        cmd_t c;
        int   nc;
        int   nr;
        logic blank;
        c = '{func: f, col: col, row: row, direction: dir, cell_letter: ltr};
        blank = 1'b0;
        nc = int'(col);
        nr = int'(row);
        if (c.func == FUNC_START && col < COLS && row < ROWS)
            blank = !grid_written[nr * COLS + nc];
        else if (c.func == FUNC_MOVE && cursor_on && path_depth > 0 && path_depth < CELLS &&
                 free_step(dir, nc, nr))
            blank = !grid_written[nr * COLS + nc];
        if (blank)
        begin
            c.func        = FUNC_LOAD;
            c.col         = POS_W'(nc);
            c.row         = POS_W'(nr);
            c.cell_letter = LETTER_W'($urandom);
        end
        if ($urandom_range(99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        req_if.valid       <= 1'b1;
        req_if.func        <= c.func;
        req_if.col         <= c.col;
        req_if.row         <= c.row;
        req_if.direction   <= c.direction;
        req_if.cell_letter <= c.cell_letter;
        do
            @(posedge clk);
        while (!req_if.ready);
        cursor_step(c);
        n_sent++;
    endtask

    // drop valid so the last command is not taken again, then drain
    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    task automatic test_no_cursor();
        send_cmd(FUNC_POP, '0, '0, DIR_UP, '0);
        send_cmd(FUNC_MOVE, '0, '0, DIR_DOWNRIGHT, '0);
        send_cmd(FUNC_READ, '0, '0, DIR_UP, '0);
        for (int f = int'(FUNC_READ) + 1; f < (1 << FUNC_W); f++)
            send_cmd(FUNC_W'(f), POS_W'($urandom), POS_W'($urandom), DIR_W'($urandom),
                     LETTER_W'($urandom));
        send_cmd(FUNC_START, POS_W'(COLS), '0, DIR_UP, '0);
        send_cmd(FUNC_START, '0, '1, DIR_UP, '0);
    endtask

    task automatic test_load_edges();
        send_cmd(FUNC_LOAD, '0, '0, DIR_UP, 8'h00);
        send_cmd(FUNC_LOAD, POS_W'(COLS - 1), POS_W'(ROWS - 1), DIR_UP, 8'hFF);
        send_cmd(FUNC_LOAD, POS_W'(COLS - 1), '0, DIR_UP, 8'hA5);
        send_cmd(FUNC_LOAD, POS_W'(COLS - 2), 3'd1, DIR_UP, 8'h3C);
        send_cmd(FUNC_LOAD, POS_W'(COLS - 3), 3'd1, DIR_UP, 8'hC3);
        // outside the grid: nothing written
        send_cmd(FUNC_LOAD, POS_W'(COLS), '0, DIR_UP, 8'h77);
        send_cmd(FUNC_LOAD, '1, '1, DIR_UP, 8'h77);
        send_cmd(FUNC_LOAD, '0, POS_W'(ROWS), DIR_UP, 8'h77);
    endtask

    task automatic test_short_path();
        send_cmd(FUNC_START, POS_W'(COLS - 1), '0, DIR_UP, '0);
        send_cmd(FUNC_MOVE, '0, '0, DIR_UP, '0);
        send_cmd(FUNC_MOVE, '0, '0, DIR_RIGHT, '0);
        send_cmd(FUNC_MOVE, '0, '0, DIR_DOWNLEFT, '0);
        send_cmd(FUNC_MOVE, '0, '0, DIR_LEFT, '0);
        // back onto the path
        send_cmd(FUNC_MOVE, '0, '0, DIR_RIGHT, '0);
        // reload under the path; stored letters stay
        send_cmd(FUNC_LOAD, POS_W'(COLS - 1), '0, DIR_UP, 8'h11);
        wait_for_results();
        send_cmd(FUNC_READ, '0, '0, DIR_UP, '0);
        send_cmd(FUNC_POP, '0, '0, DIR_UP, '0);
        send_cmd(FUNC_POP, '0, '0, DIR_UP, '0);
        send_cmd(FUNC_POP, '0, '0, DIR_UP, '0);
    endtask

    task automatic test_random_traffic();
        int               goal;
        int               pick;
        int               steps;
        int               nc;
        int               nr;
        int               idx;
        logic             flip_x;
        logic             flip_y;
        logic             swap_xy;
        logic [DIR_W-1:0] dir;
        int               snake_c [CELLS];
        int               snake_r [CELLS];
        logic [DIR_W-1:0] free_dirs [$];
        goal = n_sent + RAND_ITEMS;
        while (n_sent < goal)
        begin
            // one long stretch with no idling on either side
            idle_pct = (n_sent >= goal - 260 && n_sent < goal - 160) ? 0 : IDLE_PCT;
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                // full-depth snake from a random corner
                for (int i = 0; i < CELLS; i++)
                    if (!grid_written[i] || $urandom_range(3) == 0)
                        send_cmd(FUNC_LOAD, POS_W'(i % COLS), POS_W'(i / COLS), DIR_UP,
                                 LETTER_W'($urandom));
                flip_x  = 1'($urandom_range(1));
                flip_y  = 1'($urandom_range(1));
                swap_xy = (COLS == ROWS) ? 1'($urandom_range(1)) : 1'b0;
                for (int i = 0; i < CELLS; i++)
                begin
                    if (swap_xy)
                    begin
                        snake_r[i] = ((i / ROWS) % 2 == 0) ? i % ROWS : ROWS - 1 - i % ROWS;
                        snake_c[i] = i / ROWS;
                    end
                    else
                    begin
                        snake_c[i] = ((i / COLS) % 2 == 0) ? i % COLS : COLS - 1 - i % COLS;
                        snake_r[i] = i / COLS;
                    end
                    if (flip_x)
                        snake_c[i] = COLS - 1 - snake_c[i];
                    if (flip_y)
                        snake_r[i] = ROWS - 1 - snake_r[i];
                end
                send_cmd(FUNC_START, POS_W'(snake_c[0]), POS_W'(snake_r[0]), DIR_UP, '0);
                for (int i = 1; i < CELLS; i++)
                    send_cmd(FUNC_MOVE, '0, '0,
                             dir_toward(snake_c[i] - snake_c[i-1], snake_r[i] - snake_r[i-1]),
                             '0);
                // path full: one more move is refused
                send_cmd(FUNC_MOVE, '0, '0, DIR_W'($urandom), '0);
                send_cmd(FUNC_READ, '0, '0, DIR_UP, '0);
                repeat ($urandom_range(CELLS - 1))
                    send_cmd(FUNC_POP, '0, '0, DIR_UP, '0);
                send_cmd(FUNC_READ, '0, '0, DIR_UP, '0);
            end
            else if (pick < 60)
            begin
                // start, a mix of moves, pops and reads, then read the word
                if ($urandom_range(9) == 0)
                    send_cmd(FUNC_START, POS_W'($urandom), POS_W'($urandom), DIR_UP, '0);
                else
                    send_cmd(FUNC_START, POS_W'($urandom_range(COLS - 1)),
                             POS_W'($urandom_range(ROWS - 1)), DIR_UP, '0);
                steps = $urandom_range(1, 14);
                repeat (steps)
                begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                    begin
                        free_dirs.delete();
                        if (cursor_on && path_depth > 0)
                            for (int d = 0; d < (1 << DIR_W); d++)
                                if (free_step(DIR_W'(d), nc, nr))
                                    free_dirs.insert(free_dirs.size(), DIR_W'(d));
                        if (free_dirs.size() != 0)
                            dir = free_dirs[$urandom_range(free_dirs.size() - 1)];
                        else
                            dir = DIR_W'($urandom);
                        send_cmd(FUNC_MOVE, POS_W'($urandom), POS_W'($urandom), dir,
                                 LETTER_W'($urandom));
                    end
                    else if (pick < 82)
                        send_cmd(FUNC_MOVE, '0, '0, DIR_W'($urandom), '0);
                    else if (pick < 93)
                        send_cmd(FUNC_POP, POS_W'($urandom), POS_W'($urandom),
                                 DIR_W'($urandom), '0);
                    else
                        send_cmd(FUNC_READ, '0, '0, DIR_W'($urandom), '0);
                end
                if ($urandom_range(9) == 0)
                    wait_for_results();
                send_cmd(FUNC_READ, '0, '0, DIR_UP, '0);
            end
            else if (pick < 75)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(4) == 0)
                        send_cmd(FUNC_LOAD, POS_W'($urandom), POS_W'($urandom),
                                 DIR_W'($urandom), LETTER_W'($urandom));
                    else
                    begin
                        idx = $urandom_range(CELLS - 1);
                        send_cmd(FUNC_LOAD, POS_W'(idx % COLS), POS_W'(idx / COLS),
                                 DIR_W'($urandom), LETTER_W'($urandom));
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_cmd(FUNC_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                             DIR_W'($urandom), LETTER_W'($urandom));
            end
        end
        idle_pct = IDLE_PCT;
    endtask

    // response side: random stalls and the check of each transaction
    initial
    begin
        res_t want;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected transaction", {31'd0, rsp_if.last}, '0);
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_if.ok !== want.ok)
                        report_mismatch("ok", 32'(rsp_if.ok), 32'(want.ok));
                    if (rsp_if.letter !== want.letter)
                        report_mismatch("letter", 32'(rsp_if.letter), 32'(want.letter));
                    if (rsp_if.cur_col !== want.cur_col)
                        report_mismatch("cur_col", 32'(rsp_if.cur_col), 32'(want.cur_col));
                    if (rsp_if.cur_row !== want.cur_row)
                        report_mismatch("cur_row", 32'(rsp_if.cur_row), 32'(want.cur_row));
                    if (rsp_if.path_len !== want.path_len)
                        report_mismatch("path_len", 32'(rsp_if.path_len), 32'(want.path_len));
                    if (rsp_if.last !== want.last)
                        report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog: cycles with no transaction on either channel
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        errors     = 0;
        n_sent     = 0;
        idle_pct   = IDLE_PCT;
        path_depth = 0;
        cursor_on  = 1'b0;
        for (int i = 0; i < CELLS; i++)
        begin
            grid_copy[i]    = '0;
            grid_written[i] = 1'b0;
            path_col[i]     = '0;
            path_row[i]     = '0;
            path_letter[i]  = '0;
        end
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.func        <= '0;
        req_if.col         <= '0;
        req_if.row         <= '0;
        req_if.direction   <= '0;
        req_if.cell_letter <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_no_cursor();
        test_load_edges();
        test_short_path();
        test_random_traffic();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
